@@ sv/bpid_pkg.sv @@
// Shared constants and types for the balancing PID controller with steering.
// No dependencies; imported by bpid_div and balance_pid_with_steering_core.
package bpid_pkg;

    localparam int DIV_W = 49;
    localparam int DVS_W = 10;
    localparam int DCNT_W = 6;

    localparam logic [DVS_W-1:0] SCALE_FAR = 10'd250;
    localparam logic [DVS_W-1:0] SCALE_MID = 10'd500;
    localparam logic [DVS_W-1:0] SCALE_NEAR = 10'd1000;

    localparam logic [2:0] REG_PROP = 3'd0;
    localparam logic [2:0] REG_INTEG = 3'd1;
    localparam logic [2:0] REG_DERIV = 3'd2;
    localparam logic [2:0] REG_FAR = 3'd3;
    localparam logic [2:0] REG_MID = 3'd4;
    localparam logic [2:0] REG_MOVE = 3'd5;
    localparam logic [2:0] REG_HOLD = 3'd6;
    localparam logic [2:0] REG_TURN = 3'd7;

    localparam logic FN_STEP = 1'b0;
    localparam logic FN_CLEAR = 1'b1;
    localparam logic [1:0] SM_NONE = 2'd0;
    localparam logic [1:0] SM_FWD = 2'd1;
    localparam logic [1:0] SM_BACK = 2'd2;
    localparam logic [1:0] SM_HOLD = 2'd3;
    localparam logic [1:0] TM_STRAIGHT = 2'd0;
    localparam logic [1:0] TM_LEFT = 2'd1;
    localparam logic [1:0] TM_RIGHT = 2'd2;
    localparam logic [1:0] TM_SPARE = 2'd3;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

endpackage

@@ sv/bpid_div.sv @@
// Bit-serial restoring divider: a load step, then one quotient bit per cycle for each of the 49 dividend bits.
// Depends on bpid_pkg for widths and the request struct.
module bpid_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bpid_pkg::t_div_req         i_req,
    output logic                       o_done,
    output logic [bpid_pkg::DIV_W-1:0] o_quot
);
    import bpid_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_div;
    logic [DVS_W:0]    trial;
    logic              ge;
    logic [DVS_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_quo[DIV_W-1]};
        ge = trial >= {1'b0, r_div};
        if (ge) begin
            n_rem = DVS_W'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
                r_quo <= i_req.dividend;
                r_rem <= '0;
                r_div <= (i_req.divisor == '0) ? DVS_W'(1) : i_req.divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[DIV_W-2:0], ge};
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

@@ sv/balance_pid_with_steering_core.sv @@
// Top level of the balancing PID controller with steering and its register file.
// Depends on bpid_pkg and bpid_div.
//
// One item is taken at a time. A compute beat runs three bit-serial divisions
// on the shared divider (position correction, steering velocity, turning
// velocity), registers the target and then the error, runs three shift-and-add
// gain products, and then registers the sum and the output register. A reset
// beat goes straight to the output register stage. The divider and the
// one-bit-per-cycle multiplier set the length of a compute beat. The output
// register stage waits while an earlier result is still held by i_stall. A
// finished result waits in the output register while the next beat is accepted;
// no clearing pass follows reset.
module balance_pid_with_steering_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [1:0]  i_steer_mode,
    input  logic [1:0]  i_turn_mode,
    input  logic signed [31:0] i_pitch_angle,
    input  logic signed [31:0] i_rest_angle,
    input  logic signed [31:0] i_angle_offset,
    input  logic signed [31:0] i_turn_amount,
    input  logic signed [31:0] i_wheel_position,
    input  logic signed [15:0] i_wheel_velocity,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_left_reverse,
    output logic [15:0] o_left_magnitude,
    output logic        o_right_reverse,
    output logic [15:0] o_right_magnitude
);
    import bpid_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIVC = 4'd1;
    localparam logic [3:0] ST_DIVV = 4'd2;
    localparam logic [3:0] ST_DIVT = 4'd3;
    localparam logic [3:0] ST_TGT = 4'd4;
    localparam logic [3:0] ST_ERR = 4'd5;
    localparam logic [3:0] ST_MULP = 4'd6;
    localparam logic [3:0] ST_MULI = 4'd7;
    localparam logic [3:0] ST_MULD = 4'd8;
    localparam logic [3:0] ST_SUM = 4'd9;
    localparam logic [3:0] ST_FIN = 4'd10;

    localparam logic signed [51:0] TGT_LO = 52'sd10485760;
    localparam logic signed [51:0] TGT_HI = 52'sd13107200;
    localparam logic signed [51:0] ERR_LO = -52'sd2147483648;
    localparam logic signed [51:0] ERR_HI = 52'sd2147483647;
    localparam logic signed [49:0] INT_LO = -50'sd140737488355328;
    localparam logic signed [49:0] INT_HI = 50'sd140737488355327;

    logic [15:0] r_prop, r_integ, r_deriv;
    logic [14:0] r_far, r_mid;
    logic [9:0]  r_move, r_hold_div, r_turn_div;

    logic [3:0]  r_state;
    logic        r_launch;
    logic        r_zero;
    logic [1:0]  r_steer, r_turn;
    logic signed [31:0] r_pitch, r_rest, r_offset, r_tamt, r_pos;
    logic signed [15:0] r_vel;
    logic signed [47:0] r_int;
    logic signed [31:0] r_prev;
    logic signed [31:0] r_hold;
    logic signed [49:0] r_corr;
    logic signed [33:0] r_vs, r_vt;
    logic signed [51:0] r_tgt;
    logic signed [31:0] r_err;
    logic signed [32:0] r_diff;
    logic signed [48:0] r_mc, r_acc;
    logic [15:0] r_mg;
    logic [3:0]  r_mcnt;
    logic signed [40:0] r_p, r_d;
    logic signed [51:0] r_drive;
    logic        r_ovalid;
    logic        r_lrev, r_rrev;
    logic [15:0] r_lmag, r_rmag;

    t_div_req          div_req;
    logic              div_done;
    logic [DIV_W-1:0]  div_quot;

    logic signed [32:0] pos_err;
    logic [32:0]        pos_abs;
    logic signed [16:0] vel_ext;
    logic [15:0]        vel_abs;
    logic signed [49:0] quot_s;
    logic signed [33:0] quot_v;
    logic signed [51:0] n_tgt;
    logic signed [51:0] tgt_raw;
    logic signed [51:0] err_raw;
    logic signed [31:0] n_err;
    logic signed [48:0] acc_sum;
    logic signed [49:0] int_raw;
    logic signed [47:0] n_int;
    logic signed [33:0] vt_abs;
    logic signed [34:0] turn_raw;
    logic signed [51:0] turn_pos;
    logic signed [51:0] left_drv, right_drv;
    logic        l_rev, r_rev_n;
    logic [15:0] l_mag, r_mag_n;
    logic        cfg_wr;

    function automatic logic [16:0] drive_emit(input logic signed [51:0] drv);
        logic [51:0] mag;
        begin
            mag = drv[51] ? 52'(-drv) : 52'(drv);
            if (|mag[51:32]) begin
                drive_emit = {drv[51], 16'hFFFF};
            end else begin
                drive_emit = {drv[51], mag[31:16]};
            end
        end
    endfunction

    bpid_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    always_comb begin
        pos_err = 33'(r_pos) - 33'(r_hold);
        pos_abs = pos_err[32] ? 33'(-pos_err) : 33'(pos_err);
        vel_ext = 17'(r_vel);
        vel_abs = vel_ext[16] ? 16'(-vel_ext) : 16'(vel_ext);

        div_req.start = r_launch;
        div_req.dividend = {17'b0, vel_abs, 16'b0};
        div_req.divisor = r_move;
        case (r_state)
            ST_DIVC: begin
                div_req.dividend = {pos_abs, 16'b0};
                if (pos_abs > {18'b0, r_far}) begin
                    div_req.divisor = SCALE_FAR;
                end else if (pos_abs > {18'b0, r_mid}) begin
                    div_req.divisor = SCALE_MID;
                end else begin
                    div_req.divisor = SCALE_NEAR;
                end
            end
            ST_DIVV: begin
                div_req.divisor = (r_steer == SM_HOLD) ? r_hold_div : r_move;
            end
            ST_DIVT: begin
                div_req.divisor = r_turn_div;
            end
            default: begin
                div_req.divisor = r_move;
            end
        endcase

        quot_s = pos_err[32] ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
        quot_v = vel_ext[16] ? -$signed({2'b0, div_quot[31:0]})
                             : $signed({2'b0, div_quot[31:0]});

        tgt_raw = 52'(r_rest) - 52'(r_corr) - 52'(r_vs);
        case (r_steer)
            SM_FWD: n_tgt = 52'(r_rest) - 52'(r_offset) - 52'(r_vs);
            SM_BACK: n_tgt = 52'(r_rest) + 52'(r_offset) - 52'(r_vs);
            SM_HOLD: begin
                if (tgt_raw < TGT_LO) begin
                    n_tgt = TGT_LO;
                end else if (tgt_raw > TGT_HI) begin
                    n_tgt = TGT_HI;
                end else begin
                    n_tgt = tgt_raw;
                end
            end
            default: n_tgt = 52'(r_rest);
        endcase

        err_raw = r_tgt - 52'(r_pitch);
        if (err_raw < ERR_LO) begin
            n_err = 32'(ERR_LO);
        end else if (err_raw > ERR_HI) begin
            n_err = 32'(ERR_HI);
        end else begin
            n_err = 32'(err_raw);
        end

        acc_sum = r_mg[0] ? r_acc + r_mc : r_acc;
        int_raw = 50'(r_int) + 50'($signed(acc_sum[48:8]));
        if (int_raw < INT_LO) begin
            n_int = 48'(INT_LO);
        end else if (int_raw > INT_HI) begin
            n_int = 48'(INT_HI);
        end else begin
            n_int = 48'(int_raw);
        end

        vt_abs = r_vt[33] ? -r_vt : r_vt;
        turn_raw = 35'(r_tamt) - 35'(vt_abs);
        turn_pos = turn_raw[34] ? 52'sd0 : 52'(turn_raw);
        case (r_turn)
            TM_LEFT: begin
                left_drv = r_drive - turn_pos;
                right_drv = r_drive + turn_pos;
            end
            TM_RIGHT: begin
                left_drv = r_drive + turn_pos;
                right_drv = r_drive - turn_pos;
            end
            default: begin
                left_drv = r_drive;
                right_drv = r_drive;
            end
        endcase
        {l_rev, l_mag} = drive_emit(left_drv);
        {r_rev_n, r_mag_n} = drive_emit(right_drv);
    end

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[4:2])
            REG_PROP: prdata = {16'b0, r_prop};
            REG_INTEG: prdata = {16'b0, r_integ};
            REG_DERIV: prdata = {16'b0, r_deriv};
            REG_FAR: prdata = {17'b0, r_far};
            REG_MID: prdata = {17'b0, r_mid};
            REG_MOVE: prdata = {22'b0, r_move};
            REG_HOLD: prdata = {22'b0, r_hold_div};
            REG_TURN: prdata = {22'b0, r_turn_div};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop <= 16'd14200;
            r_integ <= 16'd142;
            r_deriv <= 16'd10886;
            r_far <= 15'd4000;
            r_mid <= 15'd2000;
            r_move <= 10'd35;
            r_hold_div <= 10'd30;
            r_turn_div <= 10'd35;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_PROP: r_prop <= pwdata[15:0];
                REG_INTEG: r_integ <= pwdata[15:0];
                REG_DERIV: r_deriv <= pwdata[15:0];
                REG_FAR: r_far <= pwdata[14:0];
                REG_MID: r_mid <= pwdata[14:0];
                REG_MOVE: r_move <= pwdata[9:0];
                REG_HOLD: r_hold_div <= pwdata[9:0];
                REG_TURN: r_turn_div <= pwdata[9:0];
                default: r_prop <= r_prop;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch <= 1'b0;
        end else begin
            r_launch <= ((r_state == ST_IDLE) && i_valid && (i_func == FN_STEP))
                     || (((r_state == ST_DIVC) || (r_state == ST_DIVV)) && div_done);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_zero <= 1'b0;
            r_ovalid <= 1'b0;
            r_int <= '0;
            r_prev <= '0;
            r_hold <= '0;
        end else begin
            if (r_ovalid && !i_stall && (r_state != ST_FIN)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_steer <= i_steer_mode;
                        r_turn <= i_turn_mode;
                        r_pitch <= i_pitch_angle;
                        r_rest <= i_rest_angle;
                        r_offset <= i_angle_offset;
                        r_tamt <= i_turn_amount;
                        r_pos <= i_wheel_position;
                        r_vel <= i_wheel_velocity;
                        if (i_func == FN_CLEAR) begin
                            r_int <= '0;
                            r_prev <= '0;
                            r_hold <= i_wheel_position;
                            r_zero <= 1'b1;
                            r_state <= ST_FIN;
                        end else begin
                            r_zero <= 1'b0;
                            r_state <= ST_DIVC;
                        end
                    end
                end
                ST_DIVC: begin
                    if (div_done) begin
                        r_corr <= quot_s;
                        r_state <= ST_DIVV;
                    end
                end
                ST_DIVV: begin
                    if (div_done) begin
                        r_vs <= quot_v;
                        r_state <= ST_DIVT;
                    end
                end
                ST_DIVT: begin
                    if (div_done) begin
                        r_vt <= quot_v;
                        r_state <= ST_TGT;
                    end
                end
                ST_TGT: begin
                    r_tgt <= n_tgt;
                    r_state <= ST_ERR;
                end
                ST_ERR: begin
                    r_err <= n_err;
                    r_diff <= 33'(n_err) - 33'(r_prev);
                    r_prev <= n_err;
                    r_mc <= 49'(n_err);
                    r_mg <= r_prop;
                    r_acc <= '0;
                    r_mcnt <= '0;
                    r_state <= ST_MULP;
                end
                ST_MULP, ST_MULI, ST_MULD: begin
                    if (r_mcnt == 4'd15) begin
                        r_acc <= '0;
                        r_mcnt <= '0;
                        if (r_state == ST_MULP) begin
                            r_p <= acc_sum[48:8];
                            r_mc <= 49'(r_err);
                            r_mg <= r_integ;
                            r_state <= ST_MULI;
                        end else if (r_state == ST_MULI) begin
                            r_int <= n_int;
                            r_mc <= 49'(r_diff);
                            r_mg <= r_deriv;
                            r_state <= ST_MULD;
                        end else begin
                            r_d <= acc_sum[48:8];
                            r_state <= ST_SUM;
                        end
                    end else begin
                        r_acc <= acc_sum;
                        r_mc <= r_mc <<< 1;
                        r_mg <= r_mg >> 1;
                        r_mcnt <= r_mcnt + 1'b1;
                    end
                end
                ST_SUM: begin
                    r_drive <= 52'(r_p) + 52'(r_int) + 52'(r_d);
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (!(r_ovalid && i_stall)) begin
                        r_ovalid <= 1'b1;
                        if (r_zero) begin
                            r_lrev <= 1'b0;
                            r_lmag <= '0;
                            r_rrev <= 1'b0;
                            r_rmag <= '0;
                        end else begin
                            r_lrev <= l_rev;
                            r_lmag <= l_mag;
                            r_rrev <= r_rev_n;
                            r_rmag <= r_mag_n;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_left_reverse = r_lrev;
    assign o_left_magnitude = r_lmag;
    assign o_right_reverse = r_rrev;
    assign o_right_magnitude = r_rmag;

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for balance_pid_with_steering_core: a table of directed
// beats and then random beats, checked against table values or a fixed-point model.
// Depends on bpid_pkg and the RTL of the controller.
`timescale 1ns / 100ps

module tb;
    import bpid_pkg::*;

    localparam longint ONE_Q16 = 65536;
    localparam longint INTEG_HI = 64'sd140737488355327;
    localparam longint INTEG_LO = -64'sd140737488355328;
    localparam logic signed [31:0] NEG_MAX = 32'sh8000_0000;
    localparam logic signed [31:0] POS_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] DEG180 = 32'sd11796480;

    typedef struct packed {
        logic func;
        logic [1:0] steer;
        logic [1:0] turn;
        logic signed [31:0] pitch;
        logic signed [31:0] rest;
        logic signed [31:0] offset;
        logic signed [31:0] turning;
        logic signed [31:0] pos;
        logic signed [15:0] vel;
    } t_beat;

    typedef struct packed {
        logic l_rev;
        logic [15:0] l_mag;
        logic r_rev;
        logic [15:0] r_mag;
    } t_drive;

    typedef struct packed {
        t_beat beat;
        logic typed;
        t_drive want;
    } t_row;

    logic i_clk, i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [4:0] paddr;
    logic [31:0] pwdata, prdata;
    logic i_valid, o_stall, i_stall, o_valid;
    logic i_func;
    logic [1:0] i_steer_mode, i_turn_mode;
    logic signed [31:0] i_pitch_angle, i_rest_angle, i_angle_offset, i_turn_amount;
    logic signed [31:0] i_wheel_position;
    logic signed [15:0] i_wheel_velocity;
    logic o_left_reverse, o_right_reverse;
    logic [15:0] o_left_magnitude, o_right_magnitude;

    balance_pid_with_steering_core DUT (.*);

    longint kp, ki, kd, far_lim, mid_lim, move_div, hold_div, turn_div;
    longint integ_acc, last_err, hold_pos;
    t_drive drive_due[$];
    int mismatches;
    int tx_idle, rx_idle;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic longint vel_scaled(longint vel, longint div);
        return (vel * ONE_Q16) / ((div == 0) ? 1 : div);
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic void to_drive(longint d, output logic rev, output logic [15:0] mag);
        longint a;
        rev = (d < 0);
        a = ((d < 0) ? -d : d) >>> 16;
        mag = (a > 65535) ? 16'hffff : a[15:0];
    endfunction

    function automatic t_drive motor_drive(t_beat b);
        t_drive r;
        longint target, err, e, ae, scale, p, d, drv, left, right, t, v;
        r = '0;
        if (b.func == FN_CLEAR) begin
            integ_acc = 0;
            last_err = 0;
            hold_pos = b.pos;
            return r;
        end
        target = b.rest;
        case (b.steer)
            SM_FWD: target = target - (longint'(b.offset) + vel_scaled(b.vel, move_div));
            SM_BACK: target = target + (longint'(b.offset) - vel_scaled(b.vel, move_div));
            SM_HOLD: begin
                e = longint'(b.pos) - hold_pos;
                ae = (e < 0) ? -e : e;
                if (ae > far_lim) scale = longint'(SCALE_FAR);
                else if (ae > mid_lim) scale = longint'(SCALE_MID);
                else scale = longint'(SCALE_NEAR);
                target = target - (e * ONE_Q16) / scale - vel_scaled(b.vel, hold_div);
                target = clip(target, 160 * ONE_Q16, 200 * ONE_Q16);
            end
            default: ;
        endcase
        err = clip(target - b.pitch, -64'sd2147483648, 64'sd2147483647);
        p = (kp * err) >>> 8;
        integ_acc = clip(integ_acc + ((ki * err) >>> 8), INTEG_LO, INTEG_HI);
        d = (kd * (err - last_err)) >>> 8;
        last_err = err;
        drv = p + integ_acc + d;
        left = drv;
        right = drv;
        if (b.turn == TM_LEFT || b.turn == TM_RIGHT) begin
            v = vel_scaled(b.vel, turn_div);
            t = longint'(b.turning) - ((v < 0) ? -v : v);
            if (t < 0) t = 0;
            left = (b.turn == TM_LEFT) ? drv - t : drv + t;
            right = (b.turn == TM_LEFT) ? drv + t : drv - t;
        end
        to_drive(left, r.l_rev, r.l_mag);
        to_drive(right, r.r_rev, r.r_mag);
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_PROP: kp = longint'(val[15:0]);
            REG_INTEG: ki = longint'(val[15:0]);
            REG_DERIV: kd = longint'(val[15:0]);
            REG_FAR: far_lim = longint'(val[14:0]);
            REG_MID: mid_lim = longint'(val[14:0]);
            REG_MOVE: move_div = longint'(val[9:0]);
            REG_HOLD: hold_div = longint'(val[9:0]);
            default: turn_div = longint'(val[9:0]);
        endcase
    endtask

    task automatic send_beat(t_beat b, logic typed, t_drive want);
        t_drive got;
        while ($urandom_range(99) < tx_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= b.func;
        i_steer_mode <= b.steer;
        i_turn_mode <= b.turn;
        i_pitch_angle <= b.pitch;
        i_rest_angle <= b.rest;
        i_angle_offset <= b.offset;
        i_turn_amount <= b.turning;
        i_wheel_position <= b.pos;
        i_wheel_velocity <= b.vel;
        do @(posedge i_clk); while (o_stall);
        got = motor_drive(b);
        drive_due.push_back(typed ? want : got);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (drive_due.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    function automatic t_beat random_beat();
        t_beat b;
        logic signed [31:0] span;
        b.func = ($urandom_range(99) < 6) ? FN_CLEAR : FN_STEP;
        b.steer = 2'($urandom_range(3));
        b.turn = 2'($urandom_range(3));
        b.vel = 16'($urandom);
        if ($urandom_range(99) < 25) begin
            b.pitch = $urandom;
            b.rest = $urandom;
            b.offset = $urandom;
            b.turning = $urandom;
            b.pos = $urandom;
        end else begin
            b.rest = DEG180 + $signed($urandom_range(2621440)) - 32'sd1310720;
            b.pitch = b.rest + $signed($urandom_range(655360)) - 32'sd327680;
            b.offset = $signed($urandom_range(327680)) - 32'sd163840;
            b.turning = $signed($urandom_range(1966080)) - 32'sd327680;
            span = 32'(2 * far_lim + 2);
            b.pos = 32'(hold_pos + $signed($urandom_range(span)) - far_lim - 1);
            if ($urandom_range(1)) b.vel = 16'($signed($urandom_range(200)) - 100);
        end
        return b;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle);
        end
    end

    always @(posedge i_clk) begin
        t_drive seen, due;
        if (i_rst_n && o_valid && !i_stall) begin
            seen = '{o_left_reverse, o_left_magnitude, o_right_reverse, o_right_magnitude};
            if (drive_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat %p", seen);
            end else begin
                due = drive_due.pop_front();
                if (seen !== due) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p got %p", due, seen);
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        t_row rows[$];
        t_beat b;
        int n;
        mismatches = 0;
        tx_idle = 14;
        rx_idle = 77;
        kp = 14200; ki = 142; kd = 10886; far_lim = 4000; mid_lim = 2000;
        move_div = 35; hold_div = 30; turn_div = 35;
        integ_acc = 0; last_err = 0; hold_pos = 0;
        i_rst_n <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        i_valid <= 1'b0; i_func <= FN_STEP; i_steer_mode <= SM_NONE;
        i_turn_mode <= TM_STRAIGHT; i_pitch_angle <= '0; i_rest_angle <= '0;
        i_angle_offset <= '0; i_turn_amount <= '0; i_wheel_position <= '0;
        i_wheel_velocity <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows = '{
            '{'{FN_CLEAR, SM_HOLD, TM_LEFT, POS_MAX, NEG_MAX, POS_MAX, POS_MAX, 32'sd0,
                16'sh7fff}, 1'b1, '0},
            '{'{FN_STEP, SM_NONE, TM_STRAIGHT, NEG_MAX, POS_MAX, 32'sd0, 32'sd0, 32'sd0,
                16'sd0}, 1'b1, '{1'b0, 16'hffff, 1'b0, 16'hffff}},
            '{'{FN_STEP, SM_NONE, TM_STRAIGHT, POS_MAX, NEG_MAX, 32'sd0, 32'sd0, 32'sd0,
                16'sd0}, 1'b1, '{1'b1, 16'hffff, 1'b1, 16'hffff}},
            '{'{FN_CLEAR, SM_NONE, TM_STRAIGHT, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                16'sd0}, 1'b1, '0},
            '{'{FN_STEP, SM_NONE, TM_STRAIGHT, DEG180, DEG180, 32'sd0, 32'sd0, 32'sd0,
                16'sd0}, 1'b1, '0},
            '{'{FN_STEP, SM_FWD, TM_LEFT, DEG180, DEG180, 32'sd65536, 32'sd655360, 32'sd5,
                16'sd70}, 1'b0, '0},
            '{'{FN_STEP, SM_BACK, TM_RIGHT, DEG180, DEG180, -32'sd65536, 32'sd655360, 32'sd5,
                -16'sd70}, 1'b0, '0},
            '{'{FN_STEP, SM_FWD, TM_SPARE, NEG_MAX, POS_MAX, POS_MAX, POS_MAX, 32'sd0,
                16'sh7fff}, 1'b0, '0},
            '{'{FN_STEP, SM_BACK, TM_LEFT, POS_MAX, NEG_MAX, NEG_MAX, NEG_MAX, 32'sd0,
                16'sh8000}, 1'b0, '0},
            '{'{FN_CLEAR, SM_NONE, TM_STRAIGHT, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd10000,
                16'sd0}, 1'b1, '0},
            '{'{FN_STEP, SM_HOLD, TM_STRAIGHT, DEG180, DEG180, 32'sd0, 32'sd0, 32'sd11000,
                16'sd3}, 1'b0, '0},
            '{'{FN_STEP, SM_HOLD, TM_LEFT, DEG180, DEG180, 32'sd0, 32'sd100000, 32'sd7000,
                -16'sd3}, 1'b0, '0},
            '{'{FN_STEP, SM_HOLD, TM_RIGHT, DEG180, DEG180, 32'sd0, 32'sd100000, 32'sd15000,
                16'sd0}, 1'b0, '0},
            '{'{FN_STEP, SM_HOLD, TM_STRAIGHT, DEG180, DEG180, 32'sd0, 32'sd0, 32'sd4000,
                16'sd0}, 1'b0, '0},
            '{'{FN_STEP, SM_HOLD, TM_STRAIGHT, DEG180, DEG180, 32'sd0, 32'sd0, 32'sd16000,
                16'sd0}, 1'b0, '0},
            '{'{FN_STEP, SM_HOLD, TM_STRAIGHT, DEG180, NEG_MAX, 32'sd0, 32'sd0, NEG_MAX,
                16'sh8000}, 1'b0, '0},
            '{'{FN_STEP, SM_HOLD, TM_STRAIGHT, DEG180, POS_MAX, 32'sd0, 32'sd0, POS_MAX,
                16'sh7fff}, 1'b0, '0},
            '{'{FN_STEP, SM_NONE, TM_LEFT, DEG180, DEG180, 32'sd0, NEG_MAX, 32'sd0,
                16'sd35}, 1'b0, '0},
            '{'{FN_STEP, SM_NONE, TM_RIGHT, DEG180, DEG180, 32'sd0, 32'sd65536, 32'sd0,
                16'sh8000}, 1'b0, '0}
        };
        foreach (rows[k]) send_beat(rows[k].beat, rows[k].typed, rows[k].want);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                1: begin
                    write_reg(REG_PROP, 32'hffff);
                    write_reg(REG_INTEG, 32'hffff);
                    write_reg(REG_DERIV, 32'hffff);
                    write_reg(REG_FAR, 32'h7fff);
                    write_reg(REG_MID, 32'h7fff);
                    write_reg(REG_MOVE, 32'h3ff);
                    write_reg(REG_HOLD, 32'h3ff);
                    write_reg(REG_TURN, 32'h3ff);
                end
                2: begin
                    write_reg(REG_PROP, 32'h0);
                    write_reg(REG_INTEG, 32'h0);
                    write_reg(REG_DERIV, 32'h0);
                    write_reg(REG_FAR, 32'h0);
                    write_reg(REG_MID, 32'h0);
                    write_reg(REG_MOVE, 32'h0);
                    write_reg(REG_HOLD, 32'h0);
                    write_reg(REG_TURN, 32'h0);
                end
                3: begin
                    write_reg(REG_PROP, $urandom_range(20000));
                    write_reg(REG_INTEG, $urandom_range(500));
                    write_reg(REG_DERIV, $urandom_range(20000));
                    write_reg(REG_FAR, $urandom_range(6000, 2000));
                    write_reg(REG_MID, $urandom_range(2000));
                    write_reg(REG_MOVE, $urandom_range(1023, 1));
                    write_reg(REG_HOLD, $urandom_range(1023, 1));
                    write_reg(REG_TURN, $urandom_range(1023, 1));
                end
                default: ;
            endcase
            for (n = 0; n < 225; n++) begin
                if (n == 75) begin
                    tx_idle = 77;
                    rx_idle = 14;
                end else if (n == 150) begin
                    tx_idle = 0;
                    rx_idle = 0;
                end else if (n == 0) begin
                    tx_idle = 14;
                    rx_idle = 77;
                end
                b = random_beat();
                send_beat(b, 1'b0, '0);
            end
            drain();
        end

        if (mismatches == 0 && drive_due.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/bpid_pkg.sv
sv/bpid_div.sv
sv/balance_pid_with_steering_core.sv
sim/tb.sv
